// File: rtl/core/blt_pkg.sv
// shared types and character codes for the line tokenizer
package blt_pkg;

	// character codes the tokenizer reacts to
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_QUOTE = 8'd34;
	localparam logic [7:0] CH_HASH  = 8'd35;

	// result queue depth, a power of two
	localparam int OUTQ_DEPTH = 4;

	// result kinds
	typedef enum logic [1:0] {
		KIND_CHAR     = 2'd0,
		KIND_CLOSE    = 2'd1,
		KIND_DROP     = 2'd2,
		KIND_LINE_END = 2'd3
	} blt_kind_t;

	// one result transaction
	typedef struct packed {
		blt_kind_t   kind;
		logic [5:0]  num;
		logic [5:0]  pos;
		logic [7:0]  ch;
		logic        last;
	} blt_res_t;

	// per-line flags
	typedef struct packed {
		logic in_quote;
		logic after_quoted;
		logic in_ws_run;
		logic hash2;
		logic skipping;
	} blt_flags_t;

	localparam blt_flags_t FLAGS_RESET = '{
		in_quote:     1'b0,
		after_quoted: 1'b1,
		in_ws_run:    1'b0,
		hash2:        1'b0,
		skipping:     1'b0
	};

endpackage

// File: rtl/core/blt_step.sv
// next-state and result logic for one line character
module blt_step #(
	parameter int MAX_TOKEN_COUNT = 32,
	parameter int TOKEN_BUFFER_LENGTH = 64,
	localparam int CW = $clog2(MAX_TOKEN_COUNT + 1),
	localparam int IW = $clog2(TOKEN_BUFFER_LENGTH)
) (
	input  logic                 ws_mode,
	input  logic [7:0]           char_in,
	input  logic [CW-1:0]        tok_cnt,
	input  logic [IW-1:0]        chr_idx,
	input  blt_pkg::blt_flags_t  flags,
	output logic [CW-1:0]        tok_cnt_nxt,
	output logic [IW-1:0]        chr_idx_nxt,
	output blt_pkg::blt_flags_t  flags_nxt,
	output blt_pkg::blt_res_t    res0,
	output blt_pkg::blt_res_t    res1,
	output logic [1:0]           res_n
);
	import blt_pkg::*;

	localparam logic [CW:0]   MAX_W    = (CW + 1)'(MAX_TOKEN_COUNT);
	localparam logic [IW-1:0] LAST_IDX = IW'(TOKEN_BUFFER_LENGTH - 1);

	function automatic blt_res_t mk_res(input blt_kind_t k, input logic [CW-1:0] num,
			input logic [IW-1:0] pos, input logic [7:0] ch);
		blt_res_t r;
		r.kind = k;
		r.num  = 6'(num);
		r.pos  = 6'(pos);
		r.ch   = ch;
		r.last = 1'b0;
		return r;
	endfunction

	logic [CW-1:0] tc;
	logic [IW-1:0] ci;
	blt_flags_t    f;
	logic [1:0]    n;
	blt_res_t      r0, r1, x;
	logic          blank, brk, delim, lim1;
	logic          do_drop, do_close, do_app;

	always_comb begin
		tc       = tok_cnt;
		ci       = chr_idx;
		f        = flags;
		n        = 2'd0;
		r0       = '0;
		r1       = '0;
		x        = '0;
		do_drop  = 1'b0;
		do_close = 1'b0;
		do_app   = 1'b0;
		delim    = 1'b0;
		blank    = (char_in == CH_SPACE) || (char_in == CH_TAB);
		brk      = (char_in == CH_NUL) || (char_in == CH_CR) || (char_in == CH_LF);
		// count reaches the limit once the token now open is closed
		lim1     = ((CW + 1)'(tok_cnt) + (CW + 1)'(1)) >= MAX_W;

		if (!flags.skipping) begin
			// decide what this character does
			if (!ws_mode) begin
				if (brk || (blank && !f.in_quote)) begin
					if (ci != '0) begin
						if (!f.after_quoted && f.hash2) begin
							do_drop    = 1'b1;
							f.skipping = 1'b1;
						end else begin
							do_close       = 1'b1;
							f.after_quoted = 1'b0;
						end
					end
				end else if (char_in == CH_QUOTE) begin
					f.in_quote = !f.in_quote;
					if (!f.in_quote && ci != '0) begin
						do_close = 1'b1;
					end else begin
						f.after_quoted = 1'b1;
					end
				end else begin
					do_app = 1'b1;
				end
			end else begin
				if (f.in_ws_run) begin
					if (brk) begin
						do_drop = (char_in == CH_NUL) && (ci != '0);
					end else if (!blank) begin
						// word character ends the whitespace token and starts a new one unless the token limit is reached
						do_close    = 1'b1;
						f.in_ws_run = 1'b0;
						if (!lim1) begin
							if (char_in == CH_QUOTE) begin
								f.in_quote = !f.in_quote;
							end
							do_app = 1'b1;
						end
					end else begin
						do_app = 1'b1;
					end
				end else begin
					delim = f.in_quote ? (char_in == CH_NUL) : (brk || blank);
					if (delim) begin
						do_close    = (ci != '0);
						f.in_ws_run = 1'b1;
						do_app      = blank && !(do_close && lim1);
					end else begin
						if (char_in == CH_QUOTE) begin
							f.in_quote = !f.in_quote;
						end
						do_app = 1'b1;
					end
				end
			end

			// drop or close the open token
			if (do_drop) begin
				x = mk_res(KIND_DROP, tc, '0, 8'd0);
				if (n == 2'd0) r0 = x; else r1 = x;
				n       = n + 2'd1;
				ci      = '0;
				f.hash2 = 1'b0;
			end
			if (do_close) begin
				x = mk_res(KIND_CLOSE, tc, '0, 8'd0);
				if (n == 2'd0) r0 = x; else r1 = x;
				n       = n + 2'd1;
				tc      = tc + CW'(1);
				ci      = '0;
				f.hash2 = 1'b0;
			end

			// append, or close a full token
			if (do_app) begin
				if (ci == LAST_IDX) begin
					x = mk_res(KIND_CLOSE, tc, '0, 8'd0);
					if (n == 2'd0) r0 = x; else r1 = x;
					n       = n + 2'd1;
					tc      = tc + CW'(1);
					ci      = '0;
					f.hash2 = 1'b0;
				end else begin
					x = mk_res(KIND_CHAR, tc, ci, char_in);
					if (n == 2'd0) r0 = x; else r1 = x;
					n = n + 2'd1;
					if (ci == IW'(1)) begin
						f.hash2 = (char_in == CH_HASH);
					end
					ci = ci + IW'(1);
				end
			end

			// token limit stops the line
			if ({1'b0, tc} >= MAX_W) begin
				f.skipping = 1'b1;
			end
		end

		// zero character closes the line
		if (char_in == CH_NUL) begin
			if (n == 2'd2) begin
				n = 2'd1;
			end
			x = mk_res(KIND_LINE_END, tc, '0, 8'd0);
			if (n == 2'd0) r0 = x; else r1 = x;
			n  = n + 2'd1;
			tc = '0;
			ci = '0;
			f  = FLAGS_RESET;
		end

		// mark the last result of this character
		if (n == 2'd1) begin
			r0.last = 1'b1;
		end else if (n == 2'd2) begin
			r1.last = 1'b1;
		end

		tok_cnt_nxt = tc;
		chr_idx_nxt = ci;
		flags_nxt   = f;
		res0        = r0;
		res1        = r1;
		res_n       = n;
	end

endmodule

// File: rtl/core/blt_outq.sv
// small result queue taking up to two results per cycle
module blt_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_n,
	input  blt_pkg::blt_res_t  res0,
	input  blt_pkg::blt_res_t  res1,
	output logic               room,
	output blt_pkg::blt_res_t  head,
	output logic               head_valid,
	input  logic               head_ready
);
	import blt_pkg::*;

	localparam int PW = $clog2(OUTQ_DEPTH);
	localparam int CNW = $clog2(OUTQ_DEPTH + 1);

	blt_res_t        mem [OUTQ_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CNW-1:0]  cnt_q;
	logic            pop;

	assign head_valid = (cnt_q != '0);
	assign head       = mem[rd_q];
	assign pop        = head_valid && head_ready;
	// room for two more results, judged on the registered count
	assign room       = cnt_q <= CNW'(OUTQ_DEPTH - 2);

	// entry storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			mem[wr_q + PW'(1)] <= res1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push_n);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + CNW'(push_n) - CNW'(pop);
		end
	end

endmodule

// File: rtl/core/basic_line_tokenizer_unit.sv
// top level of the line tokenizer: input stage, line state and result queue
//
// Characters of a text line come in on char_in (in_valid / in_ready), one per
// transaction; a zero character ends the line. Each character gives zero, one
// or two result transactions on out_valid / out_ready: a token character, a
// closed token, a dropped token or the line end with the token count, the
// last one of a character flagged by last_result.
// keep_whitespace_mode selects word mode or whitespace mode; it is written
// through cfg_valid / cfg_ready (always ready), by the user only while the
// block is idle, which the user alone must ensure. A character is
// registered on acceptance, evaluated against the line state from that
// register and its results written to a four-entry queue whose head drives
// the output. One character is taken every cycle while its results fit: the
// result queue drains one result a cycle while the receiver is ready, so a run
// of characters that give two results is taken only as fast as the queue
// drains. Characters with no result add nothing but still wait for room.
// When the receiver stalls, the queue fills and in_ready falls once the
// queue has no room for two more results; nothing is lost.
// Reset clears the line state, the input stage, the queue and the mode.
module basic_line_tokenizer_unit #(
	parameter int MAX_TOKEN_COUNT = 32,
	parameter int TOKEN_BUFFER_LENGTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        keep_whitespace_mode,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [5:0]  token_number,
	output logic [5:0]  char_position,
	output logic [7:0]  out_char,
	output logic        last_result
);
	import blt_pkg::*;

	localparam int CW = $clog2(MAX_TOKEN_COUNT + 1);
	localparam int IW = $clog2(TOKEN_BUFFER_LENGTH);

	logic           ws_mode_q;
	logic [7:0]     char_s1;
	logic           valid_s1;
	logic [CW-1:0]  tok_cnt_q, tok_cnt_nxt;
	logic [IW-1:0]  chr_idx_q, chr_idx_nxt;
	blt_flags_t     flags_q, flags_nxt;
	blt_res_t       res0, res1, head;
	logic [1:0]     step_n, push_n;
	logic           room, proceed;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			ws_mode_q <= keep_whitespace_mode;
		end
	end

	// input stage
	assign proceed  = valid_s1 && room;
	assign in_ready = !valid_s1 || proceed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
		end
	end

	// character evaluation
	blt_step #(
		.MAX_TOKEN_COUNT(MAX_TOKEN_COUNT),
		.TOKEN_BUFFER_LENGTH(TOKEN_BUFFER_LENGTH)
	) u_step (
		.ws_mode     (ws_mode_q),
		.char_in     (char_s1),
		.tok_cnt     (tok_cnt_q),
		.chr_idx     (chr_idx_q),
		.flags       (flags_q),
		.tok_cnt_nxt (tok_cnt_nxt),
		.chr_idx_nxt (chr_idx_nxt),
		.flags_nxt   (flags_nxt),
		.res0        (res0),
		.res1        (res1),
		.res_n       (step_n)
	);

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_cnt_q <= '0;
			chr_idx_q <= '0;
			flags_q   <= FLAGS_RESET;
		end else if (proceed) begin
			tok_cnt_q <= tok_cnt_nxt;
			chr_idx_q <= chr_idx_nxt;
			flags_q   <= flags_nxt;
		end
	end

	// result queue
	assign push_n = proceed ? step_n : 2'd0;

	blt_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.res0       (res0),
		.res1       (res1),
		.room       (room),
		.head       (head),
		.head_valid (out_valid),
		.head_ready (out_ready)
	);

	assign result_kind   = head.kind;
	assign token_number  = head.num;
	assign char_position = head.pos;
	assign out_char      = head.ch;
	assign last_result   = head.last;

`ifndef SYNTHESIS
	// token count never passes the limit
	a_tok_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, tok_cnt_q} <= (CW + 1)'(MAX_TOKEN_COUNT))
		else $error("token count above limit");

	// a live line is always below the token limit
	a_live_below: assert property (@(posedge clk) disable iff (!arst_n)
		!flags_q.skipping |-> ({1'b0, tok_cnt_q} < (CW + 1)'(MAX_TOKEN_COUNT)))
		else $error("line not stopped at token limit");

	// the zero character always yields a line-end result
	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		(proceed && char_s1 == CH_NUL) |-> (step_n != 2'd0))
		else $error("line end without result");

	// line state returns to reset after the zero character
	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(proceed && char_s1 == CH_NUL) |=> (tok_cnt_q == '0 && chr_idx_q == '0
			&& flags_q == FLAGS_RESET))
		else $error("line state not cleared at line end");
`endif

endmodule

// File: verif/tb.sv
// testbench for the line tokenizer: random and directed lines, checked against a local predictor
`timescale 1ns / 100ps

module tb;
	import blt_pkg::*;

	localparam int TB_MAX_TOKENS = 32;
	localparam int TB_TOKEN_LEN  = 64;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 10;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_mode = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_in = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] result_kind;
	logic [5:0] token_number;
	logic [5:0] char_position;
	logic [7:0] out_char;
	logic       last_result;

	basic_line_tokenizer_unit #(
		.MAX_TOKEN_COUNT(TB_MAX_TOKENS),
		.TOKEN_BUFFER_LENGTH(TB_TOKEN_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.keep_whitespace_mode(cfg_mode),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_in(char_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.token_number(token_number),
		.char_position(char_position),
		.out_char(out_char),
		.last_result(last_result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// stimulus and expectation stores
	logic [7:0] pending_chars[$];
	blt_res_t   expected_results[$];
	int         chars_queued = 0;
	int         chars_accepted = 0;
	int         mismatches = 0;
	int         cycle_count = 0;
	int         send_idle_pct = 0;
	int         stall_pct = 0;
	int         hold_requests = 0;
	int         holds_done = 0;
	int         hold_left = 0;

	// predictor line state
	bit         ws_mode = 1'b0;
	int         tok_count = 0;
	int         tok_len = 0;
	bit         in_quote = 1'b0;
	bit         quoted_flag = 1'b1;
	bit         blank_run = 1'b0;
	bit         hash_second = 1'b0;
	bit         line_stopped = 1'b0;
	blt_res_t   step_res[2];
	int         step_n = 0;

	// at most two results per character, extra ones are lost
	function automatic void add_result(blt_kind_t k, int num, int pos, logic [7:0] ch);
		if (step_n >= 2)
			return;
		step_res[step_n] = '{kind: k, num: num[5:0], pos: pos[5:0], ch: ch, last: 1'b0};
		step_n++;
	endfunction

	function automatic void end_token();
		add_result(KIND_CLOSE, tok_count, 0, 8'd0);
		tok_count++;
		tok_len = 0;
		hash_second = 1'b0;
	endfunction

	// a full token closes instead of growing
	function automatic void grow_token(logic [7:0] c);
		if (tok_len + 1 >= TB_TOKEN_LEN) begin
			end_token();
			return;
		end
		add_result(KIND_CHAR, tok_count, tok_len, c);
		if (tok_len == 1)
			hash_second = (c == CH_HASH);
		tok_len++;
	endfunction

	// works out the results of one accepted character
	task automatic tokenize_char(input logic [7:0] c);
		bit blank;
		bit brk;
		bit delim;
		int pass;
		step_n = 0;
		blank = (c == CH_SPACE) || (c == CH_TAB);
		brk = (c == CH_NUL) || (c == CH_CR) || (c == CH_LF);
		if (!line_stopped) begin
			if (ws_mode) begin
				// whitespace mode: a character may close one token and start another
				for (pass = 0; pass < 3; pass++) begin
					if (blank_run) begin
						if (brk) begin
							if (c == CH_NUL && tok_len > 0) begin
								add_result(KIND_DROP, tok_count, 0, 8'd0);
								tok_len = 0;
							end
							break;
						end else if (!blank) begin
							end_token();
							blank_run = 1'b0;
							if (tok_count >= TB_MAX_TOKENS)
								break;
						end else begin
							grow_token(c);
							break;
						end
					end else begin
						delim = in_quote ? (c == CH_NUL) : (brk || blank);
						if (delim) begin
							if (tok_len > 0)
								end_token();
							blank_run = 1'b1;
							if (tok_count >= TB_MAX_TOKENS || c == CH_NUL)
								break;
						end else begin
							if (c == CH_QUOTE)
								in_quote = !in_quote;
							grow_token(c);
							break;
						end
					end
				end
			end else begin
				// word mode
				delim = brk || (blank && !in_quote);
				if (delim) begin
					if (tok_len > 0) begin
						if (!quoted_flag && hash_second) begin
							add_result(KIND_DROP, tok_count, 0, 8'd0);
							tok_len = 0;
							hash_second = 1'b0;
							line_stopped = 1'b1;
						end else begin
							end_token();
							quoted_flag = 1'b0;
						end
					end
				end else if (c == CH_QUOTE) begin
					in_quote = !in_quote;
					if (!in_quote && tok_len > 0)
						end_token();
					else
						quoted_flag = 1'b1;
				end else begin
					grow_token(c);
				end
			end
			if (tok_count >= TB_MAX_TOKENS)
				line_stopped = 1'b1;
		end
		// zero character: line end result and fresh line state
		if (c == CH_NUL) begin
			if (step_n >= 2)
				step_n = 1;
			add_result(KIND_LINE_END, tok_count, 0, 8'd0);
			tok_count = 0;
			tok_len = 0;
			in_quote = 1'b0;
			quoted_flag = 1'b1;
			blank_run = 1'b0;
			hash_second = 1'b0;
			line_stopped = 1'b0;
		end
		if (step_n > 0)
			step_res[step_n - 1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			expected_results.push_back(step_res[i]);
	endtask

	// input driver: holds a character until accepted, may idle between characters
	always @(posedge clk or negedge arst_n) begin : drive_chars
		logic       v_n;
		logic [7:0] c_n;
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_in <= 8'd0;
		end else begin
			v_n = in_valid;
			c_n = char_in;
			if (in_valid && in_ready) begin
				tokenize_char(char_in);
				chars_accepted++;
				v_n = 1'b0;
			end
			if (!v_n && pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				v_n = 1'b1;
				c_n = pending_chars.pop_front();
			end
			in_valid <= v_n;
			char_in <= c_n;
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin : check_results
		blt_res_t got;
		blt_res_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = {result_kind, token_number, char_position, out_char, last_result};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: kind %0d num %0d pos %0d char %0d last %0d",
							got.kind, got.num, got.pos, got.ch, got.last);
				end else begin
					want = expected_results.pop_front();
					if (got.kind !== want.kind || got.num !== want.num || got.pos !== want.pos
						|| got.ch !== want.ch || got.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected kind %0d num %0d pos %0d char %0d last %0d, got kind %0d num %0d pos %0d char %0d last %0d",
								want.kind, want.num, want.pos, want.ch, want.last,
								got.kind, got.num, got.pos, got.ch, got.last);
					end
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// long receiver hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done != hold_requests) begin
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic push_char(input logic [7:0] c);
		pending_chars.push_back(c);
		chars_queued++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endtask

	// mostly letters, sometimes any byte that is not a separator or quote
	function automatic logic [7:0] word_char();
		logic [7:0] c;
		if ($urandom_range(0, 7) != 0)
			return 8'($urandom_range(97, 122));
		do
			c = 8'($urandom_range(1, 255));
		while (c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_SPACE || c == CH_QUOTE);
		return c;
	endfunction

	function automatic logic [7:0] blank_char();
		return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
	endfunction

	// one random line: mostly well-formed, some long, crowded or noisy ones
	task automatic push_line();
		int style;
		int n;
		style = $urandom_range(0, 19);
		if (style == 0) begin
			// overlong token or overlong blank run
			n = $urandom_range(60, 70);
			if ($urandom_range(0, 1)) begin
				if ($urandom_range(0, 1))
					push_char(CH_QUOTE);
				repeat (n) push_char(word_char());
			end else begin
				push_char(word_char());
				repeat (n) push_char(blank_char());
				push_char(word_char());
			end
			push_char(CH_NUL);
		end else if (style == 1) begin
			// a token count around the token limit, often enough to hit it
			repeat ($urandom_range(30, 36)) begin
				push_char(word_char());
				push_char(blank_char());
			end
			push_char(CH_NUL);
		end else if (style <= 3) begin
			// noise over the full byte range
			repeat ($urandom_range(1, 12)) push_char(8'($urandom_range(0, 255)));
			push_char(CH_NUL);
		end else begin
			n = $urandom_range(1, 6);
			if ($urandom_range(0, 3) == 0)
				push_char(blank_char());
			repeat (n) begin
				case ($urandom_range(0, 5))
					0, 1, 2: begin
						repeat ($urandom_range(1, 6)) push_char(word_char());
					end
					3: begin
						push_char(word_char());
						push_char(CH_HASH);
						repeat ($urandom_range(0, 3)) push_char(word_char());
					end
					4: begin
						push_char(CH_QUOTE);
						repeat ($urandom_range(0, 5))
							push_char($urandom_range(0, 3) == 0 ? blank_char() : word_char());
						if ($urandom_range(0, 7) != 0)
							push_char(CH_QUOTE);
					end
					default: begin
						push_char($urandom_range(0, 1) ? CH_CR : CH_LF);
					end
				endcase
				repeat ($urandom_range(0, 2)) push_char(blank_char());
			end
			// now and then a line runs on into the next one
			if ($urandom_range(0, 9) != 0)
				push_char(CH_NUL);
		end
	endtask

	task automatic fill_phase(input int target);
		int start;
		start = chars_queued;
		while (chars_queued - start < target)
			push_line();
	endtask

	// wait until every character is taken and every result has come
	task automatic settle();
		while (chars_accepted != chars_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input bit m);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_mode <= m;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		ws_mode = m;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// no idling: directed lines in both modes, then random lines
		write_mode(1'b0);
		push_text("a\377 \"c d\" e x#y z");
		push_char(CH_NUL);
		settle();
		write_mode(1'b1);
		push_text("a\r\nb \"c d\"\t ");
		push_char(CH_NUL);
		fill_phase(100);
		// leave a line open across the mode change
		push_text("ab \"c");
		settle();

		// sender idles
		write_mode(1'b0);
		send_idle_pct = 61;
		fill_phase(100);
		push_text(" xy");
		settle();

		// receiver stalls, with one long hold-off while characters keep coming
		write_mode(1'b1);
		send_idle_pct = 0;
		stall_pct = 61;
		hold_requests++;
		fill_phase(100);
		settle();

		// both sides idle
		write_mode(1'b0);
		send_idle_pct = 18;
		stall_pct = 18;
		fill_phase(100);
		settle();

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: files.f
rtl/core/blt_pkg.sv
rtl/core/blt_step.sv
rtl/core/blt_outq.sv
rtl/core/basic_line_tokenizer_unit.sv
verif/tb.sv
